/* rtl/qvr_pkg.sv */
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths and stage types for the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int DW   = 16;            // vector and result component width
  localparam int QFB  = 14;            // quaternion fraction bits
  localparam int QW   = QFB + 2;       // quaternion part width
  localparam int PW   = QW + DW;       // quaternion times vector product
  localparam int SQW  = 2 * QW;        // quaternion square product
  localparam int SUM_W = ((SQW > PW) ? SQW : PW) + 2;
  localparam int MUL_W = SUM_W + ((QW > DW) ? QW : DW);
  localparam int NUM_W = MUL_W + 2;    // signed numerator of one component
  localparam int NN_W  = NUM_W + 1;    // 2*|num| + n
  localparam int DD_W  = SUM_W + 1;    // 2*n
  localparam int FRONT_LAT = 4;        // register stages ahead of the dividers
  localparam int LAT   = FRONT_LAT + DW;

  // One divider lane's operands.
  typedef struct packed {
    logic [NN_W-1:0] nn;
    logic            neg;
    logic            ovf;
  } lane_in_t;

  // Everything the front end hands to the division stages.
  typedef struct packed {
    lane_in_t [2:0]  lane;
    logic [DD_W-1:0] dd;
    logic            zero;
  } front_t;

  // One divider lane's result.
  typedef struct packed {
    logic [DW-1:0] q;
    logic          neg;
    logic          ovf;
  } lane_out_t;

endpackage

/* rtl/quaternion_vector_rotate_unit.sv */
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit
// Rotates a vector by a quaternion, v' = q v q^-1, with exact rounding.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Beat contents
//   in_      input      in_valid/in_stall  quat_x/y/z/w (Q1.14), vec_x/y/z
//   out_     output     out_valid/out_stall rot_x/y/z, saturated, zero_quat
//
// One beat is accepted every cycle when the output is not held. An accepted
// beat passes four arithmetic stages, sixteen divider stages (one quotient
// bit each) and the output register before its result appears.
// The whole pipeline advances together; it holds only while a result sits in
// the output register and out_stall is high, so in_stall follows that case.
// Reset is synchronous and active low and clears only the valid bits.
//
module quaternion_vector_rotate_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [qvr_pkg::QW-1:0] in_quat_x,
  input  logic signed [qvr_pkg::QW-1:0] in_quat_y,
  input  logic signed [qvr_pkg::QW-1:0] in_quat_z,
  input  logic signed [qvr_pkg::QW-1:0] in_quat_w,
  input  logic signed [qvr_pkg::DW-1:0] in_vec_x,
  input  logic signed [qvr_pkg::DW-1:0] in_vec_y,
  input  logic signed [qvr_pkg::DW-1:0] in_vec_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [qvr_pkg::DW-1:0] out_rot_x,
  output logic signed [qvr_pkg::DW-1:0] out_rot_y,
  output logic signed [qvr_pkg::DW-1:0] out_rot_z,
  output logic                          out_saturated,
  output logic                          out_zero_quat
);
  import qvr_pkg::*;

  // The pipeline moves whenever the output register is free or being drained.
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // The rotation is computed as
  //   ((w^2 - |u|^2) v + 2 (u.v) u + 2 w (u x v)) / n
  // so a quaternion that is not of unit length still gives a pure rotation.
  front_t front;

  qvr_front u_front (
    .clk    (clk),
    .en     (en),
    .quat_x (in_quat_x),
    .quat_y (in_quat_y),
    .quat_z (in_quat_z),
    .quat_w (in_quat_w),
    .vec_x  (in_vec_x),
    .vec_y  (in_vec_y),
    .vec_z  (in_vec_z),
    .front  (front)
  );

  // Each component's magnitude is divided in its own lane; the divisor is 2n
  // and the dividend 2|num| + n, which rounds half away from zero.
  lane_out_t lane_q [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    qvr_div_lane u_lane (
      .clk  (clk),
      .en   (en),
      .din  (front.lane[i]),
      .dd   (front.dd),
      .dout (lane_q[i])
    );
  end

  // Valid bits travel alongside the data through every stage.
  logic [LAT-1:0] vld_r;
  logic [DW-1:0]  zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r <= {zero_r[DW-2:0], front.zero};
    end
  end

  // Clip each quotient to the signed result range. A negative quotient may
  // reach one step further than a positive one.
  logic signed [DW-1:0] rot_nxt [3];
  logic                 sat_nxt;
  logic                 zero_nxt;

  always_comb begin
    logic clip_hi;
    logic clip_lo;
    zero_nxt = zero_r[DW-1];
    sat_nxt  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      clip_hi = !lane_q[i].neg && (lane_q[i].ovf || lane_q[i].q[DW-1]);
      clip_lo = lane_q[i].neg && (lane_q[i].ovf ||
                (lane_q[i].q[DW-1] && (lane_q[i].q[DW-2:0] != '0)));
      if (zero_nxt) begin
        rot_nxt[i] = '0;
      end else if (clip_hi) begin
        rot_nxt[i] = {1'b0, {(DW-1){1'b1}}};
      end else if (clip_lo) begin
        rot_nxt[i] = {1'b1, {(DW-1){1'b0}}};
      end else if (lane_q[i].neg) begin
        rot_nxt[i] = ~lane_q[i].q + 1'b1;
      end else begin
        rot_nxt[i] = lane_q[i].q;
      end
      if (!zero_nxt && (clip_hi || clip_lo)) begin
        sat_nxt = 1'b1;
      end
    end
  end

  // Output register.
  logic signed [DW-1:0] rot_x_r, rot_y_r, rot_z_r;
  logic                 sat_r;
  logic                 zq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_x_r <= rot_nxt[0];
      rot_y_r <= rot_nxt[1];
      rot_z_r <= rot_nxt[2];
      sat_r   <= sat_nxt;
      zq_r    <= zero_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rot_x     = rot_x_r;
  assign out_rot_y     = rot_y_r;
  assign out_rot_z     = rot_z_r;
  assign out_saturated = sat_r;
  assign out_zero_quat = zq_r;

  // A zero quaternion gives a zero vector and never a clip.
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && zq_r |-> rot_x_r == '0 && rot_y_r == '0 && rot_z_r == '0 && !sat_r)
    else $error("zero quaternion result is not cleared");

  // A clip leaves at least one component at a range limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && sat_r |->
      rot_x_r == {1'b0, {(DW-1){1'b1}}} || rot_x_r == {1'b1, {(DW-1){1'b0}}} ||
      rot_y_r == {1'b0, {(DW-1){1'b1}}} || rot_y_r == {1'b1, {(DW-1){1'b0}}} ||
      rot_z_r == {1'b0, {(DW-1){1'b1}}} || rot_z_r == {1'b1, {(DW-1){1'b0}}})
    else $error("saturation flag without a clipped component");

  // While held, the pipeline keeps its valid bits.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while held");

endmodule

/* rtl/qvr_front.sv */
// ----------------------------------------------------------------------------
// qvr_front
// Four register stages that form the exact rotation numerators and the norm.
// ----------------------------------------------------------------------------
module qvr_front (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [qvr_pkg::QW-1:0] quat_x,
  input  logic signed [qvr_pkg::QW-1:0] quat_y,
  input  logic signed [qvr_pkg::QW-1:0] quat_z,
  input  logic signed [qvr_pkg::QW-1:0] quat_w,
  input  logic signed [qvr_pkg::DW-1:0] vec_x,
  input  logic signed [qvr_pkg::DW-1:0] vec_y,
  input  logic signed [qvr_pkg::DW-1:0] vec_z,
  output qvr_pkg::front_t               front
);
  import qvr_pkg::*;

  // Stage 1: all narrow products.
  logic signed [SQW-1:0] xx_r, yy_r, zz_r, ww_r;
  logic signed [PW-1:0]  dx_r, dy_r, dz_r;
  logic signed [PW-1:0]  yvz_r, zvy_r, zvx_r, xvz_r, xvy_r, yvx_r;
  logic signed [QW-1:0]  ux1_r, uy1_r, uz1_r, w1_r;
  logic signed [DW-1:0]  vx1_r, vy1_r, vz1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r  <= quat_x * quat_x;
      yy_r  <= quat_y * quat_y;
      zz_r  <= quat_z * quat_z;
      ww_r  <= quat_w * quat_w;
      dx_r  <= quat_x * vec_x;
      dy_r  <= quat_y * vec_y;
      dz_r  <= quat_z * vec_z;
      yvz_r <= quat_y * vec_z;
      zvy_r <= quat_z * vec_y;
      zvx_r <= quat_z * vec_x;
      xvz_r <= quat_x * vec_z;
      xvy_r <= quat_x * vec_y;
      yvx_r <= quat_y * vec_x;
      ux1_r <= quat_x;
      uy1_r <= quat_y;
      uz1_r <= quat_z;
      w1_r  <= quat_w;
      vx1_r <= vec_x;
      vy1_r <= vec_y;
      vz1_r <= vec_z;
    end
  end

  // Stage 2: norm, scalar weight, dot and cross products.
  logic signed [SUM_W-1:0] uu;
  logic signed [SUM_W-1:0] n2_r, s2_r, d2_r, cx2_r, cy2_r, cz2_r;
  logic signed [QW-1:0]    ux2_r, uy2_r, uz2_r, w2_r;
  logic signed [DW-1:0]    vx2_r, vy2_r, vz2_r;

  assign uu = SUM_W'(xx_r) + SUM_W'(yy_r) + SUM_W'(zz_r);

  always_ff @(posedge clk) begin
    if (en) begin
      n2_r  <= uu + SUM_W'(ww_r);
      s2_r  <= SUM_W'(ww_r) - uu;
      d2_r  <= SUM_W'(dx_r) + SUM_W'(dy_r) + SUM_W'(dz_r);
      cx2_r <= SUM_W'(yvz_r) - SUM_W'(zvy_r);
      cy2_r <= SUM_W'(zvx_r) - SUM_W'(xvz_r);
      cz2_r <= SUM_W'(xvy_r) - SUM_W'(yvx_r);
      ux2_r <= ux1_r;
      uy2_r <= uy1_r;
      uz2_r <= uz1_r;
      w2_r  <= w1_r;
      vx2_r <= vx1_r;
      vy2_r <= vy1_r;
      vz2_r <= vz1_r;
    end
  end

  // Stage 3: the three wide product terms of each component.
  logic signed [MUL_W-1:0] pa_r [3];
  logic signed [MUL_W-1:0] pb_r [3];
  logic signed [MUL_W-1:0] pc_r [3];
  logic signed [SUM_W-1:0] n3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r[0] <= MUL_W'(s2_r * vx2_r);
      pa_r[1] <= MUL_W'(s2_r * vy2_r);
      pa_r[2] <= MUL_W'(s2_r * vz2_r);
      pb_r[0] <= MUL_W'(d2_r * ux2_r);
      pb_r[1] <= MUL_W'(d2_r * uy2_r);
      pb_r[2] <= MUL_W'(d2_r * uz2_r);
      pc_r[0] <= MUL_W'(cx2_r * w2_r);
      pc_r[1] <= MUL_W'(cy2_r * w2_r);
      pc_r[2] <= MUL_W'(cz2_r * w2_r);
      n3_r    <= n2_r;
    end
  end

  // Stage 4: numerator, magnitude, rounding offset and range check.
  front_t front_r;
  front_t front_nxt;

  always_comb begin
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0]        mag;
    logic [NN_W-1:0]         nn;
    logic [NN_W-1:0]         lim;
    front_nxt.dd   = {n3_r[DD_W-2:0], 1'b0};
    front_nxt.zero = (n3_r == '0);
    lim = NN_W'({front_nxt.dd, {DW{1'b0}}});
    for (int i = 0; i < 3; i++) begin
      num = NUM_W'(pa_r[i]) + (NUM_W'(pb_r[i]) <<< 1) + (NUM_W'(pc_r[i]) <<< 1);
      mag = num[NUM_W-1] ? (~num + 1'b1) : num;
      nn  = {mag, 1'b0} + NN_W'(n3_r[SUM_W-2:0]);
      front_nxt.lane[i].nn  = nn;
      front_nxt.lane[i].neg = num[NUM_W-1];
      front_nxt.lane[i].ovf = (nn >= lim);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front_r <= front_nxt;
    end
  end

  assign front = front_r;

endmodule

/* rtl/qvr_div_lane.sv */
// ----------------------------------------------------------------------------
// qvr_div_lane
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module qvr_div_lane (
  input  logic                         clk,
  input  logic                         en,
  input  qvr_pkg::lane_in_t            din,
  input  logic [qvr_pkg::DD_W-1:0]     dd,
  output qvr_pkg::lane_out_t           dout
);
  import qvr_pkg::*;

  logic [DD_W-1:0] rem_s [DW+1];
  logic [DD_W-1:0] dd_s  [DW+1];
  logic [DW-1:0]   low_s [DW+1];
  logic [DW-1:0]   q_s   [DW+1];
  logic            neg_s [DW+1];
  logic            ovf_s [DW+1];

  // The upper dividend bits are below the divisor unless the overflow flag is set.
  assign rem_s[0] = DD_W'(din.nn[NN_W-1:DW]);
  assign low_s[0] = din.nn[DW-1:0];
  assign dd_s[0]  = dd;
  assign q_s[0]   = '0;
  assign neg_s[0] = din.neg;
  assign ovf_s[0] = din.ovf;

  for (genvar k = 0; k < DW; k++) begin : g_step
    logic [DD_W:0]   trial;
    logic [DD_W-1:0] rem_r;
    logic [DD_W-1:0] dd_r;
    logic [DW-1:0]   low_r;
    logic [DW-1:0]   q_r;
    logic            neg_r;
    logic            ovf_r;

    assign trial = {rem_s[k], low_s[k][DW-1]} - {1'b0, dd_s[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= trial[DD_W] ? {rem_s[k][DD_W-2:0], low_s[k][DW-1]} : trial[DD_W-1:0];
        q_r   <= {q_s[k][DW-2:0], ~trial[DD_W]};
        low_r <= {low_s[k][DW-2:0], 1'b0};
        dd_r  <= dd_s[k];
        neg_r <= neg_s[k];
        ovf_r <= ovf_s[k];
      end
    end

    assign rem_s[k+1] = rem_r;
    assign dd_s[k+1]  = dd_r;
    assign low_s[k+1] = low_r;
    assign q_s[k+1]   = q_r;
    assign neg_s[k+1] = neg_r;
    assign ovf_s[k+1] = ovf_r;
  end

  assign dout.q   = q_s[DW];
  assign dout.neg = neg_s[DW];
  assign dout.ovf = ovf_s[DW];

endmodule

/* dv/quaternion_vector_rotate_unit_tb.sv */
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit_tb
// Self-checking bench for the quaternion vector rotation unit: a directed
// table followed by random beats, each result checked against a typed-in value or a predictor.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_unit_tb;
  import qvr_pkg::*;

  // One input beat.
  typedef struct {
    logic signed [QW-1:0] qx, qy, qz, qw;
    logic signed [DW-1:0] vx, vy, vz;
  } rot_req_t;

  // One result beat.
  typedef struct {
    logic signed [DW-1:0] rx, ry, rz;
    logic                 sat;
    logic                 zq;
  } rot_res_t;

  // Directed row. When fixed is set the expected result is the one typed in,
  // otherwise it comes from the predictor.
  typedef struct {
    rot_req_t req;
    bit       fixed;
    rot_res_t res;
  } row_t;

  localparam int NUM_RANDOM = 1250;
  localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [QW-1:0] QONE = QW'(1 <<< QFB);
  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [QW-1:0] in_quat_x = '0, in_quat_y = '0, in_quat_z = '0, in_quat_w = '0;
  logic signed [DW-1:0] in_vec_x = '0, in_vec_y = '0, in_vec_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DW-1:0] out_rot_x, out_rot_y, out_rot_z;
  logic out_saturated, out_zero_quat;

  rot_res_t rotated_q[$];    // results still owed by the block, oldest first
  int       errors = 0;
  bit       quiet = 1'b0;    // suppresses idling on both sides for a stretch

  quaternion_vector_rotate_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Rounded division, halves away from zero. The denominator is positive.
  function automatic longint div_nearest(longint num, longint den);
    longint mag;
    longint quo;
    mag = (num < 0) ? -num : num;
    quo = (2 * mag + den) / (2 * den);
    return (num < 0) ? -quo : quo;
  endfunction

  // Clip one component to the result width and note whether it was clipped.
  function automatic logic signed [DW-1:0] clip_comp(longint v, inout logic sat);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (DW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      sat = 1'b1;
      return hi[DW-1:0];
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // Exact rotation v' = ((w^2 - |u|^2) v + 2 (u.v) u + 2 w (u x v)) / |q|^2.
  // The fraction scale cancels, so the parts are used as plain integers.
  function automatic rot_res_t rotate_vector(rot_req_t r);
    longint ux, uy, uz, w, vx, vy, vz;
    longint uu, nrm, s, d, cx, cy, cz;
    rot_res_t o;
    logic sat;
    ux = longint'(r.qx); uy = longint'(r.qy); uz = longint'(r.qz); w = longint'(r.qw);
    vx = longint'(r.vx); vy = longint'(r.vy); vz = longint'(r.vz);
    uu = ux * ux + uy * uy + uz * uz;
    nrm = uu + w * w;
    sat = 1'b0;
    o = '{default: '0};
    if (nrm == 0) begin
      o.zq = 1'b1;
      return o;
    end
    s = w * w - uu;
    d = ux * vx + uy * vy + uz * vz;
    cx = uy * vz - uz * vy;
    cy = uz * vx - ux * vz;
    cz = ux * vy - uy * vx;
    o.rx = clip_comp(div_nearest(s * vx + 2 * d * ux + 2 * w * cx, nrm), sat);
    o.ry = clip_comp(div_nearest(s * vy + 2 * d * uy + 2 * w * cy, nrm), sat);
    o.rz = clip_comp(div_nearest(s * vz + 2 * d * uz + 2 * w * cz, nrm), sat);
    o.sat = sat;
    return o;
  endfunction

  // Quaternion parts for random beats. Most are full random patterns; some
  // are small so that the norm is tiny, some lie within plus or minus one, and some sit on the extremes.
  function automatic logic signed [QW-1:0] pick_part(int mode);
    case (mode)
      0: return QW'($urandom_range(0, 4) - 2);
      1: return $urandom_range(0, 1) ? QMAX : QMIN;
      2: return QW'($urandom_range(0, 2 * 16384) - 16384);
      default: return QW'($urandom);
    endcase
  endfunction

  function automatic logic signed [DW-1:0] pick_comp();
    case ($urandom_range(0, 7))
      0: return VMAX;
      1: return VMIN;
      2: return DW'($urandom_range(0, 200) - 100);
      default: return DW'($urandom);
    endcase
  endfunction

  // Drive one beat and hold it until the block takes it. A beat that follows
  // with no gap keeps in_valid high rather than dropping it for a cycle.
  task automatic send_beat(rot_req_t r, bit fixed, rot_res_t res);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_quat_x <= r.qx;
    in_quat_y <= r.qy;
    in_quat_z <= r.qz;
    in_quat_w <= r.qw;
    in_vec_x  <= r.vx;
    in_vec_y  <= r.vy;
    in_vec_z  <= r.vz;
    do @(posedge clk); while (in_stall);
    rotated_q.push_back(fixed ? res : rotate_vector(r));
  endtask

  // Result side: stall for a random number of cycles, then take one beat.
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Every accepted result beat is compared with the oldest expectation.
  always @(posedge clk) begin
    rot_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (rotated_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = rotated_q.pop_front();
        if (out_rot_x !== e.rx) begin
          $error("rot_x: expected %0d, got %0d", e.rx, out_rot_x);
          errors++;
        end
        if (out_rot_y !== e.ry) begin
          $error("rot_y: expected %0d, got %0d", e.ry, out_rot_y);
          errors++;
        end
        if (out_rot_z !== e.rz) begin
          $error("rot_z: expected %0d, got %0d", e.rz, out_rot_z);
          errors++;
        end
        if (out_saturated !== e.sat) begin
          $error("saturated: expected %0b, got %0b", e.sat, out_saturated);
          errors++;
        end
        if (out_zero_quat !== e.zq) begin
          $error("zero_quat: expected %0b, got %0b", e.zq, out_zero_quat);
          errors++;
        end
      end
    end
  end

  // Stimulus. The directed table covers the zero quaternion, the identity at
  // both unit and non-unit length with extreme vectors, half turns that push
  // a component past the range, and quaternions built from extreme parts.
  initial begin
    row_t dir_rows[$];
    rot_req_t r;
    rot_res_t none;
    int qmode;
    none = '{default: '0};
    dir_rows = '{
      '{'{0, 0, 0, 0, VMAX, VMIN, 1}, 1, '{0, 0, 0, 1'b0, 1'b1}},
      '{'{0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 1'b0, 1'b1}},
      '{'{0, 0, 0, QONE, VMAX, VMIN, 0}, 1, '{VMAX, VMIN, 0, 1'b0, 1'b0}},
      '{'{0, 0, 0, QMIN, VMIN, VMAX, -1}, 1, '{VMIN, VMAX, -1, 1'b0, 1'b0}},
      '{'{0, 0, 0, QMAX, 1234, -4321, 77}, 1, '{1234, -4321, 77, 1'b0, 1'b0}},
      '{'{0, 0, 0, 1, VMAX, VMAX, VMAX}, 1, '{VMAX, VMAX, VMAX, 1'b0, 1'b0}},
      '{'{QONE, 0, 0, 0, 100, VMIN, VMAX}, 0, none},
      '{'{0, QONE, 0, 0, VMIN, 5, VMIN}, 0, none},
      '{'{0, 0, QMIN, 0, VMIN, VMIN, 9}, 0, none},
      '{'{QONE, 0, 0, QONE, 1000, 2000, 3000}, 0, none},
      '{'{0, QMAX, 0, QMAX, VMAX, VMAX, VMAX}, 0, none},
      '{'{QMAX, QMAX, QMAX, QMAX, VMAX, VMIN, VMAX}, 0, none},
      '{'{QMIN, QMIN, QMIN, QMIN, VMIN, VMIN, VMIN}, 0, none},
      '{'{QMAX, QMIN, QMAX, QMIN, VMAX, 0, VMIN}, 0, none},
      '{'{1, 0, 0, 0, VMAX, 1, -1}, 0, none},
      '{'{1, 1, 1, 1, 3, -3, 1}, 0, none},
      '{'{-1, 2, -2, 1, VMIN, VMAX, VMIN}, 0, none},
      '{'{11585, 0, 0, 11585, VMAX, VMAX, VMIN}, 0, none},
      '{'{8192, 8192, 8192, 8192, VMIN, VMAX, VMAX}, 0, none}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].res);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      // A stretch of back-to-back beats with no stall on either side.
      quiet = (i >= 400 && i < 550);
      // Let the pipeline drain completely once in the middle of the run.
      if (i == 700) begin
        in_valid <= 1'b0;
        while (rotated_q.size() != 0) @(posedge clk);
      end
      qmode = $urandom_range(0, 9);
      r.qx = pick_part(qmode);
      r.qy = pick_part(qmode);
      r.qz = pick_part(qmode);
      r.qw = pick_part(qmode);
      if ($urandom_range(0, 40) == 0) begin
        r.qx = '0;
        r.qy = '0;
        r.qz = '0;
        r.qw = '0;
      end
      r.vx = pick_comp();
      r.vy = pick_comp();
      r.vz = pick_comp();
      send_beat(r, 1'b0, none);
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    // Wait for the last results, then give the pipeline time to show any
    // stray beat before judging.
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (errors == 0)
      $display("quaternion_vector_rotate_unit_tb: clean");
    else
      $display("quaternion_vector_rotate_unit_tb: errors");
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("quaternion_vector_rotate_unit_tb: errors");
    $finish;
  end

endmodule
